@@ sv/weighted_edit_distance_assert.svh @@
// assertion macros for the weighted edit distance block
// used by the port checker, no other dependencies
`ifndef WEIGHTED_EDIT_DISTANCE_ASSERT_SVH
`define WEIGHTED_EDIT_DISTANCE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/wed_pkg.sv @@
// shared constants, types and helpers for the weighted edit distance block
// no dependencies
package wed_pkg;

  localparam int MAX_LEN   = 64;
  localparam int ALPHABET  = 26;
  localparam int COST_BITS = 16;

  localparam int CMD_W     = 3;
  localparam int LETTER_W  = 5;
  localparam int COST_W    = 16;
  localparam int DIST_W    = 24;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 32;

  localparam int LTR_IW    = $clog2(ALPHABET);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int STR_AW    = $clog2(MAX_LEN);
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int TAB_DEPTH = ALPHABET * ALPHABET;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_COST   = 3'd0,
    CMD_DEL_COST   = 3'd1,
    CMD_SUB_COST   = 3'd2,
    CMD_TRANS_COST = 3'd3,
    CMD_APPEND_SRC = 3'd4,
    CMD_APPEND_TGT = 3'd5,
    CMD_COMPUTE    = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LAT,
    ST_CELL_RD,
    ST_CELL_TB,
    ST_CELL_SUM,
    ST_CELL_MIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_we;
    logic start;
    logic row_lat;
    logic cell_tb;
    logic cell_sum;
    logic cell_min;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic compute_req;
    logic cell_end;
    logic row_end;
    logic out_free;
  } dp_stat_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic logic [TAB_AW-1:0] tab_idx(input logic [LTR_IW-1:0] a,
                                                input logic [LTR_IW-1:0] b);
    return TAB_AW'(a) * TAB_AW'(ALPHABET) + TAB_AW'(b);
  endfunction

  function automatic logic [DIST_W-1:0] cost_ext(input logic [COST_BITS-1:0] c);
    return DIST_W'(c);
  endfunction

endpackage

@@ sv/weighted_edit_distance.sv @@
// weighted restricted damerau-levenshtein distance, top level
// depends on wed_pkg, wed_ctrl, wed_dp
// loads and appends leave ready high, so the next load can be taken straight away
// compute sweeps (n+1)*(m+1) cells via cell_rd, cell_tb, cell_sum and cell_min, plus
// row_rd and row_lat per source row; cell loop is bound by the registered ram reads
// after reset the substitute and transpose tables are zeroed, all 676 entries, ready low
module weighted_edit_distance import wed_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // command[2:0], first_letter[7:3], second_letter[12:8], cost_value[28:13]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // distance[23:0], overflow[24]
  output logic [OUT_W-1:0] m_tdata
);

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic [DIST_W-1:0]  distance;
  logic               overflow;

  wed_ctrl u_ctrl (
    .clk, .rst, .stat, .cmd, .ready(s_tready)
  );

  wed_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .in_valid(s_tvalid),
    .load(s_tvalid && s_tready),
    .command(s_tdata[2:0]),
    .first_letter(s_tdata[7:3]),
    .second_letter(s_tdata[12:8]),
    .cost_value(s_tdata[28:13]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .distance,
    .overflow
  );

  assign m_tdata = {{(OUT_W - DIST_W - 1){1'b0}}, overflow, distance};

endmodule

@@ sv/wed_ram.sv @@
// generic simple dual-port ram with registered read
// no dependencies
module wed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/wed_ctrl.sv @@
// sequencer for table clearing, loads and the alignment sweep
// depends on wed_pkg
module wed_ctrl import wed_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:     if (stat.compute_req) state_next = ST_CELL_RD;
      ST_ROW_RD:   state_next = ST_ROW_LAT;
      ST_ROW_LAT:  state_next = ST_CELL_RD;
      ST_CELL_RD:  state_next = ST_CELL_TB;
      ST_CELL_TB:  state_next = ST_CELL_SUM;
      ST_CELL_SUM: state_next = ST_CELL_MIN;
      ST_CELL_MIN: begin
        if (stat.cell_end && stat.row_end) state_next = ST_DONE;
        else if (stat.cell_end) state_next = ST_ROW_RD;
        else state_next = ST_CELL_RD;
      end
      ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    ready = 1'b0;
    unique case (state)
      ST_CLEAR:    cmd.clear_we = 1'b1;
      ST_IDLE: begin
        ready = 1'b1;
        cmd.start = stat.compute_req;
      end
      ST_ROW_RD:   ;
      ST_ROW_LAT:  cmd.row_lat = 1'b1;
      ST_CELL_RD:  ;
      ST_CELL_TB:  cmd.cell_tb = 1'b1;
      ST_CELL_SUM: cmd.cell_sum = 1'b1;
      ST_CELL_MIN: cmd.cell_min = 1'b1;
      ST_DONE:     cmd.emit = stat.out_free;
      default:     ;
    endcase
  end

endmodule

@@ sv/wed_dp.sv @@
// datapath: cost tables, strings, dp rows, cell arithmetic and result register
// depends on wed_pkg and wed_ram
module wed_dp import wed_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  in_valid,
  input  logic                  load,
  input  logic [CMD_W-1:0]      command,
  input  logic [LETTER_W-1:0]   first_letter,
  input  logic [LETTER_W-1:0]   second_letter,
  input  logic [COST_W-1:0]     cost_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_W-1:0]     distance,
  output logic                  overflow
);

  logic [COST_BITS-1:0] ins_cost [ALPHABET];
  logic [COST_BITS-1:0] del_cost [ALPHABET];
  logic [LEN_W-1:0]     src_len, tgt_len, i_cnt, j_cnt;
  logic                 dropped;
  logic [TAB_AW-1:0]    clr_cnt;
  logic [1:0]           cur_row, prev_row, back_row;
  logic [LTR_IW-1:0]    sc, sp, tc, tp;
  logic [DIST_W-1:0]    prevj, b2, left, diag, res;
  logic [DIST_W-1:0]    c_ins, c_del, c_sub, c_tr;
  logic                 tr_ok;

  logic                 a_ok, b_ok;
  logic [LTR_IW-1:0]    a_l, b_l;
  logic [COST_BITS-1:0] cost;
  logic                 tab_we_sub, tab_we_tr;
  logic [TAB_AW-1:0]    tab_waddr;
  logic [COST_BITS-1:0] tab_wdata, sub_q, tr_q;
  logic                 src_we, tgt_we;
  logic [LTR_IW-1:0]    src_q, tgt_q;
  logic [DIST_W-1:0]    row_q [3];
  logic [DIST_W-1:0]    best, m1, m2;

  assign a_ok = first_letter < LETTER_W'(ALPHABET);
  assign b_ok = second_letter < LETTER_W'(ALPHABET);
  assign a_l  = LTR_IW'(first_letter);
  assign b_l  = LTR_IW'(second_letter);
  assign cost = COST_BITS'(cost_value);

  assign tab_we_sub = cmd.clear_we ||
                      (load && command == CMD_SUB_COST && a_ok && b_ok);
  assign tab_we_tr  = cmd.clear_we ||
                      (load && command == CMD_TRANS_COST && a_ok && b_ok);
  assign tab_waddr  = cmd.clear_we ? clr_cnt : tab_idx(a_l, b_l);
  assign tab_wdata  = cmd.clear_we ? '0 : cost;

  assign src_we = load && command == CMD_APPEND_SRC && a_ok &&
                  src_len < LEN_W'(MAX_LEN);
  assign tgt_we = load && command == CMD_APPEND_TGT && a_ok &&
                  tgt_len < LEN_W'(MAX_LEN);

  wed_ram #(.WIDTH(COST_BITS), .DEPTH(TAB_DEPTH)) u_sub (
    .clk, .we(tab_we_sub), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_idx(sc, tgt_q)), .rdata(sub_q)
  );

  wed_ram #(.WIDTH(COST_BITS), .DEPTH(TAB_DEPTH)) u_trans (
    .clk, .we(tab_we_tr), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_idx(sp, sc)), .rdata(tr_q)
  );

  wed_ram #(.WIDTH(LTR_IW), .DEPTH(MAX_LEN)) u_src (
    .clk, .we(src_we), .waddr(src_len[STR_AW-1:0]), .wdata(a_l),
    .raddr(STR_AW'(i_cnt - LEN_W'(1))), .rdata(src_q)
  );

  wed_ram #(.WIDTH(LTR_IW), .DEPTH(MAX_LEN)) u_tgt (
    .clk, .we(tgt_we), .waddr(tgt_len[STR_AW-1:0]), .wdata(a_l),
    .raddr(STR_AW'(j_cnt - LEN_W'(1))), .rdata(tgt_q)
  );

  for (genvar k = 0; k < 3; k++) begin : g_row
    wed_ram #(.WIDTH(DIST_W), .DEPTH(ROW_DEPTH)) u_row (
      .clk,
      .we(cmd.cell_min && cur_row == 2'(k)),
      .waddr(ROW_AW'(j_cnt)),
      .wdata(best),
      .raddr(prev_row == 2'(k) ? ROW_AW'(j_cnt) : ROW_AW'(j_cnt - LEN_W'(2))),
      .rdata(row_q[k])
    );
  end

  // cell minimum
  always_comb begin
    m1 = (c_ins < c_del) ? c_ins : c_del;
    m2 = (m1 < c_sub) ? m1 : c_sub;
    if (i_cnt == '0 && j_cnt == '0) begin
      best = '0;
    end else if (i_cnt == '0) begin
      best = c_ins;
    end else if (j_cnt == '0) begin
      best = c_del;
    end else if (tr_ok && c_tr < m2) begin
      best = c_tr;
    end else begin
      best = m2;
    end
  end

  always_comb begin
    stat.clear_last  = clr_cnt == TAB_AW'(TAB_DEPTH - 1);
    stat.compute_req = in_valid && command == CMD_COMPUTE;
    stat.cell_end    = j_cnt == tgt_len;
    stat.row_end     = i_cnt == src_len;
    stat.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ALPHABET; k++) begin
        ins_cost[k] <= '0;
        del_cost[k] <= '0;
      end
      src_len   <= '0;
      tgt_len   <= '0;
      dropped   <= 1'b0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_we) begin
        clr_cnt <= clr_cnt + TAB_AW'(1);
      end
      if (load && a_ok) begin
        case (command)
          CMD_INS_COST: ins_cost[a_l] <= cost;
          CMD_DEL_COST: del_cost[a_l] <= cost;
          CMD_APPEND_SRC: begin
            if (src_we) src_len <= src_len + LEN_W'(1);
            else dropped <= 1'b1;
          end
          CMD_APPEND_TGT: begin
            if (tgt_we) tgt_len <= tgt_len + LEN_W'(1);
            else dropped <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        src_len   <= '0;
        tgt_len   <= '0;
        dropped   <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_cnt    <= '0;
      j_cnt    <= '0;
      cur_row  <= 2'd0;
      prev_row <= 2'd2;
      back_row <= 2'd1;
    end
    if (cmd.row_lat) begin
      sp <= sc;
      sc <= src_q;
    end
    if (cmd.cell_tb) begin
      tc    <= tgt_q;
      tp    <= tc;
      prevj <= row_q[prev_row];
      b2    <= row_q[back_row];
    end
    if (cmd.cell_sum) begin
      c_ins <= sat_add(left, cost_ext(ins_cost[tc]));
      c_del <= sat_add(prevj, cost_ext(del_cost[sc]));
      c_sub <= sat_add(diag, cost_ext(sub_q));
      c_tr  <= sat_add(b2, cost_ext(tr_q));
      tr_ok <= i_cnt > LEN_W'(1) && j_cnt > LEN_W'(1) && sc == tp && sp == tc;
    end
    if (cmd.cell_min) begin
      left <= best;
      diag <= prevj;
      if (stat.cell_end) begin
        res <= best;
        if (!stat.row_end) begin
          i_cnt    <= i_cnt + LEN_W'(1);
          j_cnt    <= '0;
          cur_row  <= back_row;
          prev_row <= cur_row;
          back_row <= prev_row;
        end
      end else begin
        j_cnt <= j_cnt + LEN_W'(1);
      end
    end
    if (cmd.emit) begin
      distance <= res;
      overflow <= dropped;
    end
  end

endmodule

@@ sv/wed_checker.sv @@
// port checker for the weighted edit distance block, bound to the top level
// depends on wed_pkg and weighted_edit_distance_assert.svh
`include "weighted_edit_distance_assert.svh"
module wed_checker import wed_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `WED_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `WED_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
  `WED_ASSERT_NOW(a_clear_busy, clk, rst, $fell(rst), !s_tready, "ready during table clear")
  `WED_ASSERT_NEXT(a_compute_busy, clk, rst, s_tvalid && s_tready && s_tdata[2:0] == CMD_COMPUTE, !s_tready, "ready during compute")
  `WED_ASSERT_NEXT(a_load_ready, clk, rst, s_tvalid && s_tready && s_tdata[2:0] != CMD_COMPUTE, s_tready, "load stalled input")

endmodule

bind weighted_edit_distance wed_checker u_chk (.*);

@@ sim/weighted_edit_distance_tb.sv @@
// self-checking testbench for the weighted edit distance block
// drives cost loads, appends and computes, predicts each distance in the bench
// depends on wed_pkg and weighted_edit_distance
`timescale 1ns / 100ps

module weighted_edit_distance_tb;
  import wed_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  first_letter;
    logic [4:0]  second_letter;
    logic [15:0] cost_value;
  } edit_op_t;

  typedef struct packed {
    logic [23:0] distance;
    logic        overflow;
  } dist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  weighted_edit_distance DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [15:0] ins_tab [ALPHABET];
  logic [15:0] del_tab [ALPHABET];
  logic [15:0] sub_tab [ALPHABET][ALPHABET];
  logic [15:0] swap_tab [ALPHABET][ALPHABET];
  logic [4:0]  src_str [$];
  logic [4:0]  tgt_str [$];
  logic        dropped;

  edit_op_t     pending_ops [$];
  dist_result_t expected_dists [$];
  int  errors = 0;
  bit  stim_done = 1'b0;
  bit  hold_sink = 1'b0;
  bit  in_taken = 1'b0;
  int  hold_cycles = 0;
  longint cycle_count = 0;
  int  src_gap = 0;
  int  sink_gap = 0;

  function automatic logic [23:0] add_sat(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic logic [23:0] align_cost();
    logic [23:0] d [MAX_LEN+1][MAX_LEN+1];
    logic [23:0] best;
    int n, m;
    n = src_str.size();
    m = tgt_str.size();
    d[0][0] = 0;
    for (int j = 1; j <= m; j++) d[0][j] = add_sat(d[0][j-1], ins_tab[tgt_str[j-1]]);
    for (int i = 1; i <= n; i++) begin
      d[i][0] = add_sat(d[i-1][0], del_tab[src_str[i-1]]);
      for (int j = 1; j <= m; j++) begin
        best = add_sat(d[i][j-1], ins_tab[tgt_str[j-1]]);
        if (add_sat(d[i-1][j], del_tab[src_str[i-1]]) < best)
          best = add_sat(d[i-1][j], del_tab[src_str[i-1]]);
        if (add_sat(d[i-1][j-1], sub_tab[src_str[i-1]][tgt_str[j-1]]) < best)
          best = add_sat(d[i-1][j-1], sub_tab[src_str[i-1]][tgt_str[j-1]]);
        if (i > 1 && j > 1 && src_str[i-1] == tgt_str[j-2] && src_str[i-2] == tgt_str[j-1])
          if (add_sat(d[i-2][j-2], swap_tab[src_str[i-2]][src_str[i-1]]) < best)
            best = add_sat(d[i-2][j-2], swap_tab[src_str[i-2]][src_str[i-1]]);
        d[i][j] = best;
      end
    end
    return d[n][m];
  endfunction

  task automatic predict(edit_op_t op);
    logic in_a, in_b;
    in_a = op.first_letter < ALPHABET;
    in_b = op.second_letter < ALPHABET;
    case (op.command)
      CMD_INS_COST:   if (in_a) ins_tab[op.first_letter] = op.cost_value;
      CMD_DEL_COST:   if (in_a) del_tab[op.first_letter] = op.cost_value;
      CMD_SUB_COST:   if (in_a && in_b) sub_tab[op.first_letter][op.second_letter] = op.cost_value;
      CMD_TRANS_COST: if (in_a && in_b) swap_tab[op.first_letter][op.second_letter] = op.cost_value;
      CMD_APPEND_SRC: if (in_a) begin
        if (src_str.size() < MAX_LEN) src_str.push_back(op.first_letter);
        else dropped = 1'b1;
      end
      CMD_APPEND_TGT: if (in_a) begin
        if (tgt_str.size() < MAX_LEN) tgt_str.push_back(op.first_letter);
        else dropped = 1'b1;
      end
      CMD_COMPUTE: begin
        expected_dists.push_back('{distance: align_cost(), overflow: dropped});
        src_str.delete();
        tgt_str.delete();
        dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic edit_op_t mk(cmd_t c, int a, int b, int v);
    edit_op_t o;
    o.command = c;
    o.first_letter = a;
    o.second_letter = b;
    o.cost_value = v;
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random word pair, often one the other with swaps/edits, letters from 0 to span-1
  task automatic queue_words(int max_len, int span);
    int n, m;
    logic [4:0] w [$];
    n = $urandom_range(0, max_len);
    for (int i = 0; i < n; i++) w.push_back($urandom_range(0, span - 1));
    foreach (w[i]) pending_ops.push_back(mk(CMD_APPEND_SRC, w[i], $urandom_range(0, 31),
                                            $urandom));
    if ($urandom_range(0, 2) != 0) begin
      for (int i = 0; i + 1 < w.size(); i++)
        if ($urandom_range(0, 3) == 0) begin
          logic [4:0] t;
          t = w[i]; w[i] = w[i+1]; w[i+1] = t;
        end
      if (w.size() > 0 && $urandom_range(0, 1)) w[$urandom_range(0, w.size()-1)] =
        $urandom_range(0, span - 1);
      if ($urandom_range(0, 1)) w.push_back($urandom_range(0, span - 1));
    end else begin
      w.delete();
      m = $urandom_range(0, max_len);
      for (int i = 0; i < m; i++) w.push_back($urandom_range(0, span - 1));
    end
    foreach (w[i]) pending_ops.push_back(mk(CMD_APPEND_TGT, w[i], $urandom_range(0, 31),
                                            $urandom));
    pending_ops.push_back(mk(CMD_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom));
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
    end else begin
      if (in_taken) begin
        void'(pending_ops.pop_front());
        in_taken = 1'b0;
        src_gap = gap_len();
      end
      if (pending_ops.size() > 0 && src_gap == 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, pending_ops[0].cost_value, pending_ops[0].second_letter,
                     pending_ops[0].first_letter, pending_ops[0].command};
      end else begin
        s_tvalid <= 1'b0;
        if (src_gap > 0) src_gap--;
      end
    end
  end

  // accepted input goes through the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict(pending_ops[0]);
      in_taken = 1'b1;
    end
  end

  // sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap = gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    dist_result_t got, exp_r;
    cycle_count++;
    if (!rst && m_tvalid && m_tready) begin
      got = '{distance: m_tdata[23:0], overflow: m_tdata[24]};
      if (expected_dists.size() == 0) begin
        $error("unexpected transfer distance=%0d overflow=%0b", got.distance, got.overflow);
        errors++;
      end else begin
        exp_r = expected_dists.pop_front();
        if (got.distance !== exp_r.distance) begin
          $error("distance expected %0d actual %0d", exp_r.distance, got.distance);
          errors++;
        end
        if (got.overflow !== exp_r.overflow) begin
          $error("overflow expected %0d actual %0d", exp_r.overflow, got.overflow);
          errors++;
        end
      end
    end
    if (cycle_count > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int span;
    foreach (ins_tab[i]) begin
      ins_tab[i] = 0; del_tab[i] = 0;
      foreach (sub_tab[i][j]) begin sub_tab[i][j] = 0; swap_tab[i][j] = 0; end
    end
    dropped = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty compute, zero tables, extremes, out-of-range letters, unused command
    pending_ops.push_back(mk(CMD_COMPUTE, 0, 0, 0));
    pending_ops.push_back(mk(CMD_INS_COST, 0, 0, 16'hFFFF));
    pending_ops.push_back(mk(CMD_DEL_COST, 25, 0, 16'hFFFF));
    pending_ops.push_back(mk(CMD_SUB_COST, 25, 0, 16'h0001));
    pending_ops.push_back(mk(CMD_TRANS_COST, 0, 25, 16'h0002));
    pending_ops.push_back(mk(CMD_INS_COST, 31, 0, 16'h1234));
    pending_ops.push_back(mk(CMD_SUB_COST, 3, 26, 16'h1234));
    pending_ops.push_back(mk(CMD_TRANS_COST, 31, 31, 16'h1234));
    pending_ops.push_back(mk(CMD_APPEND_SRC, 26, 0, 0));
    pending_ops.push_back(mk(cmd_t'(3'd7), 5, 5, 16'hFFFF));
    pending_ops.push_back(mk(CMD_APPEND_SRC, 0, 0, 0));
    pending_ops.push_back(mk(CMD_APPEND_SRC, 25, 0, 0));
    pending_ops.push_back(mk(CMD_APPEND_TGT, 25, 0, 0));
    pending_ops.push_back(mk(CMD_APPEND_TGT, 0, 0, 0));
    pending_ops.push_back(mk(CMD_COMPUTE, 0, 0, 0));
    pending_ops.push_back(mk(CMD_APPEND_TGT, 0, 0, 0));
    pending_ops.push_back(mk(CMD_COMPUTE, 31, 31, 16'hFFFF));

    // full strings and overflow
    for (int i = 0; i < 26; i++) pending_ops.push_back(mk(CMD_INS_COST, i, 0, 16'hFFFF));
    for (int i = 0; i < MAX_LEN + 1; i++) pending_ops.push_back(mk(CMD_APPEND_TGT, 0, 0, 0));
    for (int i = 0; i < MAX_LEN + 1; i++) pending_ops.push_back(mk(CMD_APPEND_SRC, 1, 0, 0));
    pending_ops.push_back(mk(CMD_COMPUTE, 0, 0, 0));

    // long sink stall while the sender keeps going
    hold_sink = 1'b1;
    for (int k = 0; k < 6; k++) queue_words(3, 4);
    for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk);
    hold_sink = 1'b0;

    for (int round = 0; round < 60; round++) begin
      wait (pending_ops.size() == 0);
      if (round % 10 == 0) begin
        wait (expected_dists.size() == 0);
        @(posedge clk);
      end
      span = (round % 3 == 0) ? 26 : $urandom_range(2, 5);
      for (int k = 0; k < 6; k++) begin
        edit_op_t o;
        o.command = $urandom_range(0, 3);
        o.first_letter = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
                         $urandom_range(0, span - 1);
        o.second_letter = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
                          $urandom_range(0, span - 1);
        o.cost_value = ($urandom_range(0, 7) == 0) ? 16'hFFFF - $urandom_range(0, 3) :
                       $urandom_range(0, 40);
        pending_ops.push_back(o);
      end
      if ($urandom_range(0, 4) == 0) pending_ops.push_back(mk(cmd_t'($urandom_range(0, 7)),
        $urandom_range(0, 31), $urandom_range(0, 31), $urandom));
      for (int k = 0; k < 2; k++) queue_words((round == 30) ? MAX_LEN : 8, span);
    end

    wait (pending_ops.size() == 0 && !s_tvalid);
    wait (expected_dists.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_dists.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
